FILE: hdl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// Parking barrier controller package
// Shared constants and types for the parking barrier controller.
// ----------------------------------------------------------------------------
package pbc_pkg;

	localparam logic [1:0] PH_WAIT     = 2'd0;
	localparam logic [1:0] PH_CAR      = 2'd1;
	localparam logic [1:0] PH_CLOSING  = 2'd2;
	localparam logic [1:0] PH_COOLDOWN = 2'd3;

	localparam logic [1:0] REG_DAY_THRESHOLD    = 2'd0;
	localparam logic [1:0] REG_CAR_DISTANCE_CM  = 2'd1;
	localparam logic [1:0] REG_CLOSE_SECONDS    = 2'd2;
	localparam logic [1:0] REG_COOLDOWN_SECONDS = 2'd3;

	localparam logic [4:0] DUTY_OPEN   = 5'd15;
	localparam logic [4:0] DUTY_CLOSED = 5'd5;

	localparam logic [1:0] ARRIVE_BEEPS  = 2'd3;
	localparam logic [7:0] ARRIVE_ON_MS  = 8'd150;
	localparam logic [6:0] ARRIVE_OFF_MS = 7'd80;
	localparam logic [1:0] CLOSE_BEEPS   = 2'd1;
	localparam logic [7:0] CLOSE_ON_MS   = 8'd200;
	localparam logic [6:0] CLOSE_OFF_MS  = 7'd0;

	localparam logic [6:0] FULL_LIGHT      = 7'd100;
	localparam logic [6:0] RST_DAY_THRESH  = 7'd40;
	localparam logic [8:0] RST_CAR_DIST    = 9'd80;
	localparam logic [3:0] RST_CLOSE_SEC   = 4'd3;
	localparam logic [3:0] RST_COOLDOWN_SEC = 4'd3;

	localparam logic [8:0]  SOUND_NUM  = 9'd343;
	localparam logic [14:0] SOUND_DEN  = 15'd20000;
	localparam int          PROD_W     = 25;

	typedef struct packed {
		logic       gate_open;
		logic [4:0] servo_duty;
		logic       is_day;
		logic [1:0] phase;
		logic [1:0] beep_count;
		logic [7:0] beep_on_ms;
		logic [6:0] beep_off_ms;
		logic [3:0] remain_seconds;
		logic [6:0] light_percent;
		logic       car_present;
	} result_t;

endpackage

FILE: hdl/parking_barrier_controller_core.sv
// ----------------------------------------------------------------------------
// Parking barrier controller core
// Light-driven day/night barrier control with ultrasonic car detection.
// ----------------------------------------------------------------------------
// The block accepts one control-loop item per clock cycle while the input is
// not stalled. An accepted item is held in an input register, evaluated by
// short logic against the mode and night-phase state, and its result is
// registered when the output advances. The state updates as the item
// moves into the result register, so the next item sees it. While a finished
// result waits to be taken, one more item can enter the input register; after
// that the input stalls until the result leaves.
module parking_barrier_controller_core #(
	parameter int unsigned ECHO_TIMEOUT_US = 50000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  light_adc,
	input  logic        light_valid,
	input  logic [15:0] echo_first_us,
	input  logic        echo_first_valid,
	input  logic [15:0] echo_second_us,
	input  logic        echo_second_valid,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        gate_open,
	output logic [4:0]  servo_duty,
	output logic        is_day,
	output logic [1:0]  phase,
	output logic [1:0]  beep_count,
	output logic [7:0]  beep_on_ms,
	output logic [6:0]  beep_off_ms,
	output logic [3:0]  remain_seconds,
	output logic [6:0]  light_percent,
	output logic        car_present
);
	import pbc_pkg::*;

	localparam logic [15:0] TIMEOUT = 16'(ECHO_TIMEOUT_US);

	logic [6:0]  day_threshold_q;
	logic [8:0]  car_distance_q;
	logic [3:0]  close_seconds_q;
	logic [3:0]  cooldown_seconds_q;

	logic        mode_known_q;
	logic        day_mode_q;
	logic [1:0]  night_phase_q;
	logic [31:0] phase_start_q;
	logic        barrier_q;

	logic        valid_s1;
	logic [7:0]  light_adc_s1;
	logic        light_valid_s1;
	logic [15:0] echo_first_s1;
	logic        echo_first_valid_s1;
	logic [15:0] echo_second_s1;
	logic        echo_second_valid_s1;
	logic [31:0] now_s1;

	logic        valid_s2;
	result_t     res_s2;

	logic        advance;
	logic [14:0] light_prod;
	logic [6:0]  quot_est;
	logic [14:0] quot_rem;
	logic [6:0]  quot;
	logic [6:0]  light;
	logic        day_now;
	logic [PROD_W-1:0] dist_limit;
	logic        first_near;
	logic        second_near;
	logic        car;
	logic [31:0] elapsed;
	logic        next_barrier;
	logic        next_day_mode;
	logic [1:0]  next_phase;
	logic [31:0] next_start;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_threshold_q    <= RST_DAY_THRESH;
			car_distance_q     <= RST_CAR_DIST;
			close_seconds_q    <= RST_CLOSE_SEC;
			cooldown_seconds_q <= RST_COOLDOWN_SEC;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DAY_THRESHOLD:    day_threshold_q    <= cfg_data[6:0];
				REG_CAR_DISTANCE_CM:  car_distance_q     <= cfg_data;
				REG_CLOSE_SECONDS:    close_seconds_q    <= cfg_data[3:0];
				REG_COOLDOWN_SECONDS: cooldown_seconds_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			light_adc_s1         <= light_adc;
			light_valid_s1       <= light_valid;
			echo_first_s1        <= echo_first_us;
			echo_first_valid_s1  <= echo_first_valid;
			echo_second_s1       <= echo_second_us;
			echo_second_valid_s1 <= echo_second_valid;
			now_s1               <= now_seconds;
		end
	end

	// The product is below 2^15, so the estimate from a shift by eight is at
	// most one short of the true quotient by 255.
	assign light_prod = 15'(light_adc_s1) * 15'd100;
	assign quot_est   = light_prod[14:8];
	assign quot_rem   = light_prod - {quot_est, 8'b0} + 15'(quot_est);
	assign quot       = quot_est + 7'(quot_rem >= 15'd255);
	assign light      = light_valid_s1 ? (FULL_LIGHT - quot) : FULL_LIGHT;
	assign day_now    = light > day_threshold_q;

	assign dist_limit  = PROD_W'(car_distance_q) * PROD_W'(SOUND_DEN);
	assign first_near  = echo_first_valid_s1 && (echo_first_s1 != 16'd0)
		&& (echo_first_s1 <= TIMEOUT)
		&& (PROD_W'(echo_first_s1) * PROD_W'(SOUND_NUM) < dist_limit);
	assign second_near = echo_second_valid_s1 && (echo_second_s1 != 16'd0)
		&& (echo_second_s1 <= TIMEOUT)
		&& (PROD_W'(echo_second_s1) * PROD_W'(SOUND_NUM) < dist_limit);
	assign car         = first_near && second_near;
	assign elapsed     = now_s1 - phase_start_q;

	always_comb begin
		next_barrier  = barrier_q;
		next_day_mode = day_mode_q;
		next_phase    = night_phase_q;
		next_start    = phase_start_q;
		res           = '0;

		if (!mode_known_q) begin
			next_day_mode = day_now;
			next_barrier  = day_now;
			next_phase    = PH_WAIT;
		end else if (day_now != day_mode_q) begin
			next_barrier  = day_now;
			next_day_mode = day_now;
			if (!day_now) begin
				next_phase = PH_WAIT;
			end
		end

		if (!day_now) begin
			unique case (next_phase)
				PH_WAIT: begin
					if (car) begin
						next_barrier    = 1'b1;
						res.beep_count  = ARRIVE_BEEPS;
						res.beep_on_ms  = ARRIVE_ON_MS;
						res.beep_off_ms = ARRIVE_OFF_MS;
						next_phase      = PH_CAR;
					end
				end
				PH_CAR: begin
					if (!car) begin
						next_start         = now_s1;
						next_phase         = PH_CLOSING;
						res.remain_seconds = close_seconds_q;
					end
				end
				PH_CLOSING: begin
					if (elapsed >= 32'(close_seconds_q)) begin
						next_barrier       = 1'b0;
						res.beep_count     = CLOSE_BEEPS;
						res.beep_on_ms     = CLOSE_ON_MS;
						res.beep_off_ms    = CLOSE_OFF_MS;
						next_start         = now_s1;
						next_phase         = PH_COOLDOWN;
						res.remain_seconds = cooldown_seconds_q;
					end else begin
						res.remain_seconds = close_seconds_q - elapsed[3:0];
					end
				end
				PH_COOLDOWN: begin
					if (elapsed >= 32'(cooldown_seconds_q)) begin
						next_phase = PH_WAIT;
					end else begin
						res.remain_seconds = cooldown_seconds_q - elapsed[3:0];
					end
				end
				default: ;
			endcase
		end

		res.gate_open     = next_barrier;
		res.servo_duty    = next_barrier ? DUTY_OPEN : DUTY_CLOSED;
		res.is_day        = day_now;
		res.phase         = day_now ? PH_WAIT : next_phase;
		res.light_percent = light;
		res.car_present   = car;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_known_q  <= 1'b0;
			day_mode_q    <= 1'b0;
			night_phase_q <= PH_WAIT;
			phase_start_q <= 32'd0;
			barrier_q     <= 1'b0;
		end else if (valid_s1 && advance) begin
			mode_known_q  <= 1'b1;
			day_mode_q    <= next_day_mode;
			night_phase_q <= next_phase;
			phase_start_q <= next_start;
			barrier_q     <= next_barrier;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign gate_open      = res_s2.gate_open;
	assign servo_duty     = res_s2.servo_duty;
	assign is_day         = res_s2.is_day;
	assign phase          = res_s2.phase;
	assign beep_count     = res_s2.beep_count;
	assign beep_on_ms     = res_s2.beep_on_ms;
	assign beep_off_ms    = res_s2.beep_off_ms;
	assign remain_seconds = res_s2.remain_seconds;
	assign light_percent  = res_s2.light_percent;
	assign car_present    = res_s2.car_present;

	// At night the barrier is open exactly while a car is here or closing runs.
	a_night_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_day |->
			gate_open == ((phase == PH_CAR) || (phase == PH_CLOSING)))
		else $error("night barrier position disagrees with phase");

	// In day mode the barrier is open with no phase, countdown or beeps.
	a_day_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_day |->
			gate_open && (phase == PH_WAIT) && (remain_seconds == 4'd0)
			&& (beep_count == 2'd0))
		else $error("day result shows night activity");

	// The state may only move when an item leaves the input register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=>
			$stable(night_phase_q) && $stable(barrier_q) && $stable(phase_start_q))
		else $error("controller state changed without an item");

endmodule

FILE: test/tb_parking_barrier_controller_core.sv
// ----------------------------------------------------------------------------
// Parking barrier controller core testbench
// Drives control-loop items through the valid/stall input channel, predicts
// every result with an independent model of the day/night barrier logic, and
// compares each returned result field by field. A directed opening covers the
// light, echo and timer corner cases, then random day/night car episodes run
// under several register settings with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_parking_barrier_controller_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pbc_pkg::*;

	localparam int ECHO_LIMIT_US = 50000;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [7:0]  adc;
		logic        adc_ok;
		logic [15:0] e1;
		logic        e1_ok;
		logic [15:0] e2;
		logic        e2_ok;
		logic [31:0] now;
	} loop_pass_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic out_valid;
	logic out_stall;
	logic gate_open;
	logic [4:0] servo_duty;
	logic is_day;
	logic [1:0] phase;
	logic [1:0] beep_count;
	logic [7:0] beep_on_ms;
	logic [6:0] beep_off_ms;
	logic [3:0] remain_seconds;
	logic [6:0] light_percent;
	logic car_present;

	loop_pass_t drv;
	loop_pass_t pending_passes[$];
	result_t predicted_status[$];

	logic [6:0] thr_pct;
	logic [8:0] dist_cm;
	logic [3:0] close_s;
	logic [3:0] cool_s;

	logic st_known;
	logic st_day;
	logic [1:0] st_phase;
	logic [31:0] st_start;
	logic st_open;

	logic in_taken;
	logic quiet;
	int send_gap;
	int stall_left;
	int mismatches;
	int cycles;

	logic [31:0] sim_now;
	logic car_want;
	logic night_want;
	int car_hold;
	int mode_hold;

	parking_barrier_controller_core #(
		.ECHO_TIMEOUT_US(ECHO_LIMIT_US)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.light_adc(drv.adc),
		.light_valid(drv.adc_ok),
		.echo_first_us(drv.e1),
		.echo_first_valid(drv.e1_ok),
		.echo_second_us(drv.e2),
		.echo_second_valid(drv.e2_ok),
		.now_seconds(drv.now),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gate_open(gate_open),
		.servo_duty(servo_duty),
		.is_day(is_day),
		.phase(phase),
		.beep_count(beep_count),
		.beep_on_ms(beep_on_ms),
		.beep_off_ms(beep_off_ms),
		.remain_seconds(remain_seconds),
		.light_percent(light_percent),
		.car_present(car_present)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic echo_near(logic [15:0] us, logic ok);
		if (!ok || us == 16'd0 || int'(us) > ECHO_LIMIT_US) return 1'b0;
		return (32'(us) * 32'(SOUND_NUM)) < (32'(dist_cm) * 32'(SOUND_DEN));
	endfunction

	function automatic result_t predict_barrier(loop_pass_t p);
		result_t r;
		logic [6:0] pct;
		logic day;
		logic car;
		logic [31:0] elapsed;
		r = '0;
		pct = FULL_LIGHT;
		if (p.adc_ok) pct = 7'(32'd100 - (32'(p.adc) * 32'd100) / 32'd255);
		day = pct > thr_pct;
		car = echo_near(p.e1, p.e1_ok) && echo_near(p.e2, p.e2_ok);
		if (!st_known) begin
			st_known = 1'b1;
			st_day = day;
			st_open = day;
			st_phase = PH_WAIT;
		end else if (day != st_day) begin
			st_open = day;
			if (!day) st_phase = PH_WAIT;
			st_day = day;
		end
		if (!day) begin
			elapsed = p.now - st_start;
			case (st_phase)
				PH_WAIT: begin
					if (car) begin
						st_open = 1'b1;
						r.beep_count = ARRIVE_BEEPS;
						r.beep_on_ms = ARRIVE_ON_MS;
						r.beep_off_ms = ARRIVE_OFF_MS;
						st_phase = PH_CAR;
					end
				end
				PH_CAR: begin
					if (!car) begin
						st_start = p.now;
						st_phase = PH_CLOSING;
						r.remain_seconds = close_s;
					end
				end
				PH_CLOSING: begin
					if (elapsed >= 32'(close_s)) begin
						st_open = 1'b0;
						r.beep_count = CLOSE_BEEPS;
						r.beep_on_ms = CLOSE_ON_MS;
						r.beep_off_ms = CLOSE_OFF_MS;
						st_start = p.now;
						st_phase = PH_COOLDOWN;
						r.remain_seconds = cool_s;
					end else begin
						r.remain_seconds = 4'(32'(close_s) - elapsed);
					end
				end
				default: begin
					if (elapsed >= 32'(cool_s)) st_phase = PH_WAIT;
					else r.remain_seconds = 4'(32'(cool_s) - elapsed);
				end
			endcase
		end
		r.gate_open = st_open;
		r.servo_duty = st_open ? DUTY_OPEN : DUTY_CLOSED;
		r.is_day = day;
		r.phase = day ? PH_WAIT : st_phase;
		r.light_percent = pct;
		r.car_present = car;
		return r;
	endfunction

	function automatic int field_width(int i);
		case (i)
			0, 2, 9: return 1;
			1: return 5;
			3, 4: return 2;
			5: return 8;
			6, 8: return 7;
			default: return 4;
		endcase
	endfunction

	function automatic string field_name(int i);
		case (i)
			0: return "gate_open";
			1: return "servo_duty";
			2: return "is_day";
			3: return "phase";
			4: return "beep_count";
			5: return "beep_on_ms";
			6: return "beep_off_ms";
			7: return "remain_seconds";
			8: return "light_percent";
			default: return "car_present";
		endcase
	endfunction

	task automatic check_result();
		result_t got;
		result_t want;
		logic [63:0] gv;
		logic [63:0] wv;
		int shift;
		got = {gate_open, servo_duty, is_day, phase, beep_count, beep_on_ms, beep_off_ms,
			remain_seconds, light_percent, car_present};
		if (predicted_status.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			mismatches++;
		end else begin
			want = predicted_status.pop_front();
			shift = $bits(result_t);
			for (int i = 0; i < 10; i++) begin
				shift -= field_width(i);
				gv = (64'(got) >> shift) & ((64'd1 << field_width(i)) - 64'd1);
				wv = (64'(want) >> shift) & ((64'd1 << field_width(i)) - 64'd1);
				if (gv !== wv) begin
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time,
						field_name(i), wv, gv);
					mismatches++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && !in_stall;
			if (out_valid && !out_stall) check_result();
			if (in_taken) predicted_status.push_back(predict_barrier(drv));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_passes.size() > 0) begin
				drv <= pending_passes.pop_front();
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	task automatic add_pass(logic [7:0] adc, logic adc_ok, logic [15:0] e1, logic e1_ok,
			logic [15:0] e2, logic e2_ok, logic [31:0] now);
		pending_passes.push_back({adc, adc_ok, e1, e1_ok, e2, e2_ok, now});
	endtask

	function automatic logic [15:0] pick_echo(logic want, int near_max, output logic ok);
		int r;
		r = $urandom_range(0, 99);
		ok = 1'b1;
		if (r < 5) begin
			ok = 1'b0;
			return 16'($urandom);
		end
		if (r < 8) return 16'd0;
		if (r < 12 && near_max > 0) return 16'(near_max + $urandom_range(0, 1));
		if (want && near_max > 0 && r < 90) return 16'($urandom_range(1, near_max));
		if (r < 95) return 16'($urandom);
		return 16'($urandom_range(near_max < 65535 ? near_max + 1 : 65535, 65535));
	endfunction

	task automatic add_random_passes(int count);
		loop_pass_t p;
		int near_max;
		int r;
		near_max = 0;
		if (dist_cm != 0) near_max = (int'(dist_cm) * 20000 - 1) / 343;
		if (near_max > ECHO_LIMIT_US) near_max = ECHO_LIMIT_US;
		repeat (count) begin
			if (car_hold == 0) begin
				car_want = !car_want;
				car_hold = $urandom_range(1, 8);
			end
			car_hold--;
			if (mode_hold == 0) begin
				night_want = ($urandom_range(0, 3) != 0);
				mode_hold = $urandom_range(5, 60);
			end
			mode_hold--;
			r = $urandom_range(0, 99);
			p.adc_ok = (r >= 4);
			if (r < 14) p.adc = 8'($urandom_range(0, 255));
			else if (night_want) p.adc = 8'($urandom_range(200, 255));
			else p.adc = 8'($urandom_range(0, 60));
			r = $urandom_range(0, 99);
			if (r < 3) sim_now = $urandom;
			else if (r < 60) sim_now += 32'd1;
			else if (r >= 85) sim_now += 32'($urandom_range(2, 4));
			p.now = sim_now;
			p.e1 = pick_echo(car_want, near_max, p.e1_ok);
			p.e2 = pick_echo(car_want, near_max, p.e2_ok);
			pending_passes.push_back(p);
		end
	endtask

	task automatic wait_idle();
		while (pending_passes.size() > 0 || in_valid || predicted_status.size() > 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_regs(logic [8:0] thr, logic [8:0] near_cm, logic [8:0] cls,
			logic [8:0] cool);
		logic [1:0] idx [4];
		logic [8:0] val [4];
		idx = '{REG_DAY_THRESHOLD, REG_CAR_DISTANCE_CM, REG_CLOSE_SECONDS,
			REG_COOLDOWN_SECONDS};
		val = '{thr, near_cm, cls, cool};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		thr_pct = thr[6:0];
		dist_cm = near_cm;
		close_s = cls[3:0];
		cool_s = cool[3:0];
	endtask

	task automatic run_phase(int thr, int near_cm, int cls, int cool, int count);
		wait_idle();
		set_regs(9'(thr), 9'(near_cm), 9'(cls), 9'(cool));
		quiet = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 2) == 0) sim_now = 32'hFFFF_FFF0;
		add_random_passes(count);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		drv = '0;
		in_taken = 1'b0;
		quiet = 1'b0;
		send_gap = 0;
		stall_left = 0;
		mismatches = 0;
		cycles = 0;
		sim_now = 32'd100;
		car_want = 1'b0;
		night_want = 1'b1;
		car_hold = 0;
		mode_hold = 0;
		thr_pct = RST_DAY_THRESH;
		dist_cm = RST_CAR_DIST;
		close_s = RST_CLOSE_SEC;
		cool_s = RST_COOLDOWN_SEC;
		st_known = 1'b0;
		st_day = 1'b0;
		st_phase = PH_WAIT;
		st_start = '0;
		st_open = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_pass(8'd255, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0, 32'd0);
		add_pass(8'd255, 1'b1, 16'd1, 1'b1, 16'd1, 1'b1, 32'd0);
		add_pass(8'd255, 1'b1, 16'd4664, 1'b1, 16'd4664, 1'b1, 32'd0);
		add_pass(8'd255, 1'b1, 16'd4665, 1'b1, 16'd4664, 1'b1, 32'd0);
		add_pass(8'd255, 1'b1, 16'd100, 1'b0, 16'd100, 1'b0, 32'd1);
		add_pass(8'd255, 1'b1, 16'hFFFF, 1'b1, 16'd0, 1'b1, 32'd3);
		add_pass(8'd255, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 32'd4);
		add_pass(8'd255, 1'b1, 16'd50000, 1'b1, 16'd50000, 1'b1, 32'd6);
		add_pass(8'd255, 1'b1, 16'd50001, 1'b1, 16'd10, 1'b1, 32'd7);
		add_pass(8'd255, 1'b0, 16'd10, 1'b1, 16'd10, 1'b1, 32'd8);
		add_pass(8'd0, 1'b1, 16'd10, 1'b1, 16'd10, 1'b1, 32'd9);
		add_pass(8'd153, 1'b1, 16'd10, 1'b1, 16'd10, 1'b1, 32'd10);
		add_pass(8'd152, 1'b1, 16'd10, 1'b1, 16'd10, 1'b1, 32'd11);
		add_pass(8'd255, 1'b1, 16'd10, 1'b1, 16'd10, 1'b0, 32'd12);
		add_pass(8'd200, 1'b1, 16'd10, 1'b1, 16'd10, 1'b1, 32'hFFFF_FFFE);
		add_pass(8'd200, 1'b1, 16'd9000, 1'b1, 16'd10, 1'b1, 32'hFFFF_FFFF);
		add_pass(8'd200, 1'b1, 16'd9000, 1'b1, 16'd9000, 1'b1, 32'd1);
		add_pass(8'd200, 1'b1, 16'd9000, 1'b1, 16'd9000, 1'b1, 32'd2);
		add_pass(8'd200, 1'b1, 16'd10, 1'b1, 16'd10, 1'b1, 32'd3);
		add_pass(8'd200, 1'b1, 16'd10, 1'b1, 16'd10, 1'b1, 32'd5);

		run_phase(0, 1, 0, 0, 90);
		run_phase(100, 400, 15, 15, 100);
		run_phase(127, 80, 1, 2, 90);
		run_phase(40, 0, 3, 3, 60);
		repeat (4) run_phase($urandom_range(20, 80), $urandom_range(20, 400),
			$urandom_range(0, 15), $urandom_range(0, 15), 100);

		wait_idle();
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/pbc_pkg.sv
hdl/parking_barrier_controller_core.sv
test/tb_parking_barrier_controller_core.sv
